// File: rtl/wrhp_pkg.sv
package wrhp_pkg;

  // chunk ids as they sit little-endian in the tag register
  localparam logic [31:0] TagFmt  = 32'h20746D66;
  localparam logic [31:0] TagData = 32'h61746164;

  localparam int unsigned HdrLen    = 12;
  localparam int unsigned FmtCapLen = 16;
  localparam int unsigned MsPerSec  = 1000;

  // dividend width of the shared divider: 32-bit length times 1000
  localparam int unsigned DivW    = 42;
  localparam int unsigned DivCntW = $clog2(DivW);

  localparam logic [30:0] DurMax = 31'h7FFF_FFFF;

  localparam int unsigned OutW = 176;

  typedef enum logic [3:0] {
    PH_HEADER,
    PH_CHDR,
    PH_FMT,
    PH_SKIP,
    PH_DONE,
    PH_DUR_GO,
    PH_DUR_WAIT,
    PH_FRM_GO,
    PH_FRM_WAIT
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_DATA = 2'd1,
    ST_NO_FMT  = 2'd2,
    ST_ZERO_DIV = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CNT_HOLD,
    CNT_CLEAR,
    CNT_INC,
    CNT_DEC,
    CNT_LOAD_CHDR,
    CNT_LOAD_FMT
  } cnt_op_e;

  typedef struct packed {
    logic    restart;
    logic    chdr_wr;
    logic    fmt_wr;
    logic    set_fmt_seen;
    cnt_op_e cnt_op;
    logic    emit_data;
    logic    emit_nodata;
    logic    out_set;
    logic    div_start;
    logic    div_frm;
    logic    wr_dur;
    logic    wr_frame;
  } cmd_t;

  typedef struct packed {
    logic hdr_last;
    logic chdr_last;
    logic tag_data;
    logic tag_fmt;
    logic len_ge16;
    logic len_zero;
    logic fmt_last;
    logic fmt_rem_zero;
    logic skip_last;
    logic div_ok;
    logic out_free;
    logic div_done;
  } stat_t;

endpackage

// File: rtl/wrhp_div.sv
module wrhp_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [wrhp_pkg::DivW-1:0]   dividend_i,
  input  logic [31:0]                 divisor_i,
  output logic                        done_o,
  output logic [wrhp_pkg::DivW-1:0]   quot_o
);

  logic [wrhp_pkg::DivW-1:0]    quo_q, quo_d;
  logic [31:0]                  rem_q, rem_d;
  logic [31:0]                  dvs_q, dvs_d;
  logic [wrhp_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [32:0]                  rem_sh;
  logic [32:0]                  rem_diff;
  logic                         fits;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh   = {rem_q, quo_q[wrhp_pkg::DivW-1]};
    rem_diff = rem_sh - {1'b0, dvs_q};
    fits     = (rem_sh >= {1'b0, dvs_q});
    quo_d    = quo_q;
    rem_d    = rem_q;
    dvs_d    = dvs_q;
    cnt_d    = cnt_q;
    busy_d   = busy_q;
    done_d   = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[wrhp_pkg::DivW-2:0], fits};
      rem_d = fits ? rem_diff[31:0] : rem_sh[31:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == wrhp_pkg::DivCntW'(wrhp_pkg::DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

endmodule

// File: rtl/wrhp_dp.sv
module wrhp_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [7:0]                   byte_i,
  input  wrhp_pkg::cmd_t               cmd_i,
  input  logic                         out_ready_i,
  output wrhp_pkg::stat_t              stat_o,
  output logic                         out_valid_o,
  output logic [wrhp_pkg::OutW-1:0]    out_data_o
);

  logic [31:0] cnt_q, cnt_d, cnt_eff;
  logic [31:0] tag_q, len_q;
  logic [31:0] len_full;
  logic [15:0] chan_q;
  logic [31:0] rate_q, brate_q;
  logic        fmt_seen_q;
  logic        out_valid_q;

  wrhp_pkg::status_e ost_q;
  logic [31:0] orate_q, obrate_q, olen_q;
  logic [15:0] ochan_q;
  logic [30:0] odur_q, ofrm_q;

  logic [wrhp_pkg::DivW-1:0] dividend;
  logic [31:0]               divisor;
  logic [wrhp_pkg::DivW-1:0] quot;
  logic                      div_done;
  logic [2:0]                hidx;
  logic [3:0]                fidx;

  assign cnt_eff  = cmd_i.restart ? '0 : cnt_q;
  assign len_full = {byte_i, len_q[23:0]};
  assign hidx     = cnt_q[2:0];
  assign fidx     = cnt_q[3:0];

  always_comb begin
    stat_o.hdr_last     = (cnt_eff == 32'(wrhp_pkg::HdrLen - 1));
    stat_o.chdr_last    = (hidx == 3'd7);
    stat_o.tag_data     = (tag_q == wrhp_pkg::TagData);
    stat_o.tag_fmt      = (tag_q == wrhp_pkg::TagFmt);
    stat_o.len_ge16     = (len_full >= 32'(wrhp_pkg::FmtCapLen));
    stat_o.len_zero     = (len_full == '0);
    stat_o.fmt_last     = (fidx == 4'(wrhp_pkg::FmtCapLen - 1));
    stat_o.fmt_rem_zero = (len_q == 32'(wrhp_pkg::FmtCapLen));
    stat_o.skip_last    = (cnt_q == 32'd1);
    stat_o.div_ok       = fmt_seen_q && (chan_q != '0) && (brate_q != '0);
    stat_o.out_free     = !out_valid_q || out_ready_i;
    stat_o.div_done     = div_done;
  end

  always_comb begin
    unique case (cmd_i.cnt_op)
      wrhp_pkg::CNT_HOLD:      cnt_d = cnt_q;
      wrhp_pkg::CNT_CLEAR:     cnt_d = '0;
      wrhp_pkg::CNT_INC:       cnt_d = cnt_eff + 32'd1;
      wrhp_pkg::CNT_DEC:       cnt_d = cnt_q - 32'd1;
      wrhp_pkg::CNT_LOAD_CHDR: cnt_d = len_full;
      wrhp_pkg::CNT_LOAD_FMT:  cnt_d = len_q - 32'(wrhp_pkg::FmtCapLen);
      default:                 cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      fmt_seen_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.restart) begin
        fmt_seen_q <= 1'b0;
      end else if (cmd_i.set_fmt_seen) begin
        fmt_seen_q <= 1'b1;
      end
      if (cmd_i.out_set) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // chunk header and format capture, one byte lane per word
  always_ff @(posedge clk_i) begin
    if (cmd_i.chdr_wr) begin
      if (!hidx[2]) begin
        tag_q[8*hidx[1:0] +: 8] <= byte_i;
      end else begin
        len_q[8*hidx[1:0] +: 8] <= byte_i;
      end
    end
    if (cmd_i.fmt_wr) begin
      if (fidx == 4'd2 || fidx == 4'd3) begin
        chan_q[8*fidx[0] +: 8] <= byte_i;
      end else if (fidx[3:2] == 2'd1) begin
        rate_q[8*fidx[1:0] +: 8] <= byte_i;
      end else if (fidx[3:2] == 2'd2) begin
        brate_q[8*fidx[1:0] +: 8] <= byte_i;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_nodata) begin
      ost_q    <= wrhp_pkg::ST_NO_DATA;
      orate_q  <= '0;
      ochan_q  <= '0;
      obrate_q <= '0;
      olen_q   <= '0;
      odur_q   <= '0;
      ofrm_q   <= '0;
    end else if (cmd_i.emit_data) begin
      if (!fmt_seen_q) begin
        ost_q <= wrhp_pkg::ST_NO_FMT;
      end else if (!stat_o.div_ok) begin
        ost_q <= wrhp_pkg::ST_ZERO_DIV;
      end else begin
        ost_q <= wrhp_pkg::ST_OK;
      end
      orate_q  <= fmt_seen_q ? rate_q : '0;
      ochan_q  <= fmt_seen_q ? chan_q : '0;
      obrate_q <= fmt_seen_q ? brate_q : '0;
      olen_q   <= len_full;
      odur_q   <= '0;
      ofrm_q   <= '0;
    end
    if (cmd_i.wr_dur) begin
      odur_q <= (|quot[wrhp_pkg::DivW-1:31]) ? wrhp_pkg::DurMax : quot[30:0];
    end
    if (cmd_i.wr_frame) begin
      ofrm_q <= quot[30:0];
    end
  end

  always_comb begin
    if (cmd_i.div_frm) begin
      dividend = wrhp_pkg::DivW'(len_q);
      divisor  = {15'd0, chan_q, 1'b0};
    end else begin
      dividend = wrhp_pkg::DivW'(len_q) * wrhp_pkg::DivW'(wrhp_pkg::MsPerSec);
      divisor  = brate_q;
    end
  end

  wrhp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {ofrm_q, odur_q, olen_q, obrate_q, ochan_q, orate_q, ost_q};

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_set |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before it was taken");

endmodule

// File: rtl/wrhp_ctrl.sv
module wrhp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_first_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  input  wrhp_pkg::stat_t  stat_i,
  output wrhp_pkg::cmd_t   cmd_o
);

  wrhp_pkg::phase_e state_q, state_d, phase;
  logic accept;
  logic emitted;
  logic parsing;

  assign parsing = (state_q == wrhp_pkg::PH_HEADER) || (state_q == wrhp_pkg::PH_CHDR) ||
                   (state_q == wrhp_pkg::PH_FMT) || (state_q == wrhp_pkg::PH_SKIP) ||
                   (state_q == wrhp_pkg::PH_DONE);
  assign in_ready_o = parsing && stat_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wrhp_pkg::PH_HEADER;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    emitted = 1'b0;
    phase   = in_first_i ? wrhp_pkg::PH_HEADER : state_q;
    if (accept) begin
      cmd_o.restart = in_first_i;
      unique case (phase)
        wrhp_pkg::PH_HEADER: begin
          if (stat_i.hdr_last) begin
            cmd_o.cnt_op = wrhp_pkg::CNT_CLEAR;
            state_d      = wrhp_pkg::PH_CHDR;
          end else begin
            cmd_o.cnt_op = wrhp_pkg::CNT_INC;
            state_d      = wrhp_pkg::PH_HEADER;
          end
        end
        wrhp_pkg::PH_CHDR: begin
          cmd_o.chdr_wr = 1'b1;
          if (!stat_i.chdr_last) begin
            cmd_o.cnt_op = wrhp_pkg::CNT_INC;
          end else if (stat_i.tag_data) begin
            cmd_o.emit_data = 1'b1;
            cmd_o.cnt_op    = wrhp_pkg::CNT_CLEAR;
            emitted         = 1'b1;
            if (stat_i.div_ok) begin
              state_d = wrhp_pkg::PH_DUR_GO;
            end else begin
              cmd_o.out_set = 1'b1;
              state_d       = wrhp_pkg::PH_DONE;
            end
          end else if (stat_i.tag_fmt && stat_i.len_ge16) begin
            cmd_o.cnt_op = wrhp_pkg::CNT_CLEAR;
            state_d      = wrhp_pkg::PH_FMT;
          end else begin
            cmd_o.cnt_op = wrhp_pkg::CNT_LOAD_CHDR;
            state_d      = stat_i.len_zero ? wrhp_pkg::PH_CHDR : wrhp_pkg::PH_SKIP;
          end
        end
        wrhp_pkg::PH_FMT: begin
          cmd_o.fmt_wr = 1'b1;
          if (stat_i.fmt_last) begin
            cmd_o.set_fmt_seen = 1'b1;
            cmd_o.cnt_op       = wrhp_pkg::CNT_LOAD_FMT;
            state_d = stat_i.fmt_rem_zero ? wrhp_pkg::PH_CHDR : wrhp_pkg::PH_SKIP;
          end else begin
            cmd_o.cnt_op = wrhp_pkg::CNT_INC;
          end
        end
        wrhp_pkg::PH_SKIP: begin
          cmd_o.cnt_op = wrhp_pkg::CNT_DEC;
          if (stat_i.skip_last) begin
            state_d = wrhp_pkg::PH_CHDR;
          end
        end
        default: begin
          state_d = state_q;
        end
      endcase
      // end of file while still walking chunks
      if (in_last_i && !emitted &&
          (state_d == wrhp_pkg::PH_HEADER || state_d == wrhp_pkg::PH_CHDR ||
           state_d == wrhp_pkg::PH_FMT || state_d == wrhp_pkg::PH_SKIP)) begin
        cmd_o.emit_nodata = 1'b1;
        cmd_o.out_set     = 1'b1;
        cmd_o.cnt_op      = wrhp_pkg::CNT_CLEAR;
        state_d           = wrhp_pkg::PH_DONE;
      end
    end else begin
      unique case (state_q)
        wrhp_pkg::PH_DUR_GO: begin
          cmd_o.div_start = 1'b1;
          state_d         = wrhp_pkg::PH_DUR_WAIT;
        end
        wrhp_pkg::PH_DUR_WAIT: begin
          if (stat_i.div_done) begin
            cmd_o.wr_dur = 1'b1;
            state_d      = wrhp_pkg::PH_FRM_GO;
          end
        end
        wrhp_pkg::PH_FRM_GO: begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_frm   = 1'b1;
          state_d         = wrhp_pkg::PH_FRM_WAIT;
        end
        wrhp_pkg::PH_FRM_WAIT: begin
          cmd_o.div_frm = 1'b1;
          if (stat_i.div_done) begin
            cmd_o.wr_frame = 1'b1;
            cmd_o.out_set  = 1'b1;
            state_d        = wrhp_pkg::PH_DONE;
          end
        end
        default: begin
          state_d = state_q;
        end
      endcase
    end
  end

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.div_done |-> (state_q == wrhp_pkg::PH_DUR_WAIT ||
                         state_q == wrhp_pkg::PH_FRM_WAIT))
    else $error("divider finished outside a wait state");

  a_div_then_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wrhp_pkg::PH_DUR_GO) |=> (state_q == wrhp_pkg::PH_DUR_WAIT))
    else $error("duration division not started");

endmodule

// File: rtl/wav_riff_header_parser_top.sv
// output: a result word is valid in the cycle after the byte that completes a data chunk
// header or ends the file; with a usable format it waits for the two divisions instead
// throughput: one byte per cycle while the result word is free, except a stall after a data
// chunk header while the shared 42-step divider computes duration and frame count
// reset: asynchronous active low, parser returns to the riff header skip phase
module wav_riff_header_parser_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // file_byte [7:0]
  input  logic [7:0]                  s_axis_tdata_i,
  // first_byte: restarts the parse on this byte
  input  logic                        s_axis_tuser_i,
  // last_byte
  input  logic                        s_axis_tlast_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // status [1:0], sample_rate [33:2], channel_count [49:34], byte_rate [81:50],
  // data_length [113:82], duration_ms [144:114], frame_total [175:145]
  output logic [wrhp_pkg::OutW-1:0]   m_axis_tdata_o
);

  wrhp_pkg::cmd_t  cmd;
  wrhp_pkg::stat_t stat;

  // controller walks header, chunk headers, fmt capture and chunk skips,
  // then sequences the two divisions for a data chunk
  wrhp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_first_i (s_axis_tuser_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath holds the byte counter, chunk id and size, the captured format,
  // the shared divider and the result word register
  wrhp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_i      (s_axis_tdata_i),
    .cmd_i       (cmd),
    .out_ready_i (m_axis_tready_i),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule
